[rtl/core/voigt_ft_2d_evaluator_core_defines.svh]
// assertion macros for the pseudo-Voigt evaluator core
// no dependencies
`ifndef VOIGT_FT_2D_EVALUATOR_CORE_DEFINES_SVH
`define VOIGT_FT_2D_EVALUATOR_CORE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define VFT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication with the consequent checked in the cycle after the antecedent
`define VFT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/vft_pkg.sv]
// shared types, codes and table node functions for the evaluator core
// no dependencies
package vft_pkg;

  typedef enum logic [1:0] {
    MODE_CAUCHY = 2'd0,
    MODE_GAUSS  = 2'd1,
    MODE_VOIGT  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_WIDTH_X = 2'd1;
  localparam logic [1:0] REG_WIDTH_Y = 2'd2;
  localparam logic [1:0] REG_ETA     = 2'd3;

  localparam int NodeW = 25;
  localparam int ValW  = 19;
  localparam logic signed [23:0] ValMax = 24'sd196607;
  localparam logic signed [23:0] ValMin = -24'sd131072;

  typedef logic [NodeW-1:0] node_t;

  // shift-subtract quotient, used only while building the tables
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned exp_neg_q31(input longint unsigned f);
    longint unsigned term;
    longint acc;
    term = 64'd1 << 31;
    acc = longint'(term);
    for (int k = 1; k <= 20; k++) begin
      term = (term * f) >> 31;
      term = udiv64(term, 64'(k));
      if (k[0]) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    return longint'(acc);
  endfunction

  function automatic longint unsigned isqrt64(input longint unsigned v_in);
    longint unsigned v;
    longint unsigned res;
    longint unsigned bit_w;
    v = v_in;
    res = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic node_t gauss_node(input longint unsigned x);
    longint unsigned n;
    longint unsigned f;
    longint unsigned r;
    longint unsigned e1;
    longint unsigned i;
    n = x >> 17;
    f = (x & 64'h1FFFF) << 14;
    r = exp_neg_q31(f);
    e1 = exp_neg_q31(64'd1 << 31);
    i = 0;
    while (i < n && r != 0) begin
      r = (r * e1) >> 31;
      i = i + 1;
    end
    return NodeW'((r + 64) >> 7);
  endfunction

  function automatic node_t cauchy_node(input longint unsigned x);
    longint unsigned u;
    longint unsigned r;
    longint unsigned p;
    u = 64'd65536 + x;
    r = isqrt64(u << 24);
    p = u * r;
    return NodeW'(udiv64(64'd1 << 60, p));
  endfunction

endpackage

[rtl/core/vft_rom.sv]
// constant node table with two registered read ports
// depends on vft_pkg
module vft_rom #(
  parameter int TABLE_DEPTH = 1024,
  parameter bit GAUSS = 1'b0,
  parameter int AW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic clk,
  input  logic en,
  input  logic [AW-1:0] idx,
  output vft_pkg::node_t d0,
  output vft_pkg::node_t d1
);

  typedef vft_pkg::node_t rom_t [0:TABLE_DEPTH];

  function automatic rom_t build_rom();
    rom_t t;
    longint unsigned x;
    for (int k = 0; k <= TABLE_DEPTH; k++) begin
      x = vft_pkg::udiv64(64'(k) << 24, 64'(TABLE_DEPTH));
      if (GAUSS) t[k] = vft_pkg::gauss_node(x);
      else t[k] = vft_pkg::cauchy_node(x);
    end
    return t;
  endfunction

  localparam rom_t Rom = build_rom();

  logic [AW-1:0] idx_p1;
  assign idx_p1 = idx + AW'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      d0 <= Rom[idx];
      d1 <= Rom[idx_p1];
    end
  end

endmodule

[rtl/core/voigt_ft_2d_evaluator_core.sv]
// channel  | signals                     | carries
// in       | in_valid, in_stall          | q_x, q_y
// out      | out_valid, out_stall        | value, clipped
// cfg      | cfg_we, cfg_index, cfg_data | profile_mode, width_x, width_y, mix_eta
// nine register stages, one request per cycle except while in_stall holds the input
// the multiplier stages and the two-port table read set the stage count
// synchronous reset clears valid bits and config registers, data registers and tables need no clearing
// a stalled output holds; bubbles collapse, input stalls only when all stages are full
// top level of the pseudo-Voigt evaluator, depends on vft_pkg, vft_rom and the defines header
`include "voigt_ft_2d_evaluator_core_defines.svh"
module voigt_ft_2d_evaluator_core #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [15:0] q_x,
  input  logic signed [15:0] q_y,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [18:0] value,
  output logic clipped,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH + 1);
  localparam int NS = 9;

  vft_pkg::mode_t profile_mode;
  logic [15:0] width_x;
  logic [15:0] width_y;
  logic signed [15:0] mix_eta;

  always_ff @(posedge clk) begin
    if (rst) begin
      profile_mode <= vft_pkg::MODE_CAUCHY;
      width_x <= 16'd256;
      width_y <= 16'd256;
      mix_eta <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        vft_pkg::REG_MODE: profile_mode <= vft_pkg::mode_t'(cfg_data[1:0]);
        vft_pkg::REG_WIDTH_X: width_x <= cfg_data;
        vft_pkg::REG_WIDTH_Y: width_y <= cfg_data;
        vft_pkg::REG_ETA: mix_eta <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  logic [NS:1] v;
  logic [NS+1:1] adv;

  always_comb begin
    adv[NS+1] = !out_stall;
    for (int k = NS; k >= 1; k--) adv[k] = !v[k] || adv[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = NS; k >= 2; k--) if (adv[k]) v[k] <= v[k-1];
      if (adv[1]) v[1] <= in_valid;
    end
  end

  assign in_stall = !adv[1];
  assign out_valid = v[NS];

  // stage 1: scale by widths
  logic signed [32:0] px, py;
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      px <= 33'(q_x) * 33'($signed({1'b0, width_x}));
      py <= 33'(q_y) * 33'($signed({1'b0, width_y}));
    end
  end

  // stage 2: squares
  logic [32:0] nx, ny;
  logic [31:0] ax, ay;
  logic [63:0] sqx, sqy;
  assign nx = px[32] ? 33'(-px) : 33'(px);
  assign ny = py[32] ? 33'(-py) : 33'(py);
  assign ax = nx[31:0];
  assign ay = ny[31:0];
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      sqx <= 64'(ax) * 64'(ax);
      sqy <= 64'(ay) * 64'(ay);
    end
  end

  // stage 3: round and saturate the sum
  logic [63:0] sum;
  logic [15:0] s3;
  logic clip3;
  assign sum = sqx + sqy + (64'd1 << 31);
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      if (|sum[63:48]) begin
        s3 <= 16'hFFFF;
        clip3 <= 1'b1;
      end else begin
        s3 <= sum[47:32];
        clip3 <= 1'b0;
      end
    end
  end

  // stage 4: table position
  logic [31:0] pos;
  logic [AW-1:0] idx4;
  logic [15:0] fr4;
  logic clip4;
  assign pos = 32'(s3) * 32'(TABLE_DEPTH);
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      idx4 <= pos[16 +: AW];
      fr4 <= pos[15:0];
      clip4 <= clip3;
    end
  end

  // stage 5: table read
  vft_pkg::node_t g0, g1, c0, c1;
  logic [15:0] fr5;
  logic clip5;

  vft_rom #(.TABLE_DEPTH(TABLE_DEPTH), .GAUSS(1'b1), .AW(AW)) u_gauss_rom (
    .clk(clk), .en(adv[5]), .idx(idx4), .d0(g0), .d1(g1)
  );
  vft_rom #(.TABLE_DEPTH(TABLE_DEPTH), .GAUSS(1'b0), .AW(AW)) u_cauchy_rom (
    .clk(clk), .en(adv[5]), .idx(idx4), .d0(c0), .d1(c1)
  );

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      fr5 <= fr4;
      clip5 <= clip4;
    end
  end

  // stage 6: interpolation products
  logic [16:0] w1, w0;
  logic [41:0] pg0, pg1, pc0, pc1;
  logic clip6;
  assign w1 = 17'(fr5);
  assign w0 = 17'h10000 - w1;
  always_ff @(posedge clk) begin
    if (adv[6]) begin
      pg0 <= 42'(g0) * 42'(w0);
      pg1 <= 42'(g1) * 42'(w1);
      pc0 <= 42'(c0) * 42'(w0);
      pc1 <= 42'(c1) * 42'(w1);
      clip6 <= clip5;
    end
  end

  // stage 7: interpolation sums
  logic [41:0] sg, sc;
  vft_pkg::node_t g7, c7;
  logic clip7;
  assign sg = pg0 + pg1;
  assign sc = pc0 + pc1;
  always_ff @(posedge clk) begin
    if (adv[7]) begin
      g7 <= sg[40:16];
      c7 <= sc[40:16];
      clip7 <= clip6;
    end
  end

  // stage 8: mix weights
  logic signed [17:0] eta_c;
  logic signed [43:0] mg, mc;
  vft_pkg::node_t g8, c8;
  logic clip8;
  assign eta_c = 18'sd16384 - 18'(mix_eta);
  always_ff @(posedge clk) begin
    if (adv[8]) begin
      mg <= 44'(mix_eta) * 44'($signed({1'b0, g7}));
      mc <= 44'(eta_c) * 44'($signed({1'b0, c7}));
      g8 <= g7;
      c8 <= c7;
      clip8 <= clip7;
    end
  end

  // stage 9: select, round and saturate
  logic signed [43:0] mix;
  logic signed [23:0] val;
  logic [NS-1:0] unused_fill;
  logic clip_pre;
  assign mix = mg + mc + 44'sd2097152;
  assign unused_fill = '0;

  always_comb begin
    clip_pre = clip8;
    case (profile_mode)
      vft_pkg::MODE_CAUCHY: val = $signed(24'((26'(c8) + 26'd128) >> 8));
      vft_pkg::MODE_GAUSS: val = $signed(24'((26'(g8) + 26'd128) >> 8));
      vft_pkg::MODE_VOIGT: val = 24'(mix >>> 22);
      default: begin
        val = '0;
        clip_pre = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      if (val > vft_pkg::ValMax) begin
        value <= vft_pkg::ValMax[18:0];
        clipped <= 1'b1;
      end else if (val < vft_pkg::ValMin) begin
        value <= vft_pkg::ValMin[18:0];
        clipped <= 1'b1;
      end else begin
        value <= val[18:0];
        clipped <= clip_pre;
      end
    end
  end

  `VFT_ASSERT_IMP(a_stall_full, in_stall, (v == {NS{1'b1}}) && out_stall, "input stalled with room in pipeline")
  `VFT_ASSERT_IMP(a_plain_nonneg, out_valid && (profile_mode == vft_pkg::MODE_CAUCHY || profile_mode == vft_pkg::MODE_GAUSS), !value[18], "negative single-profile value")
  `VFT_ASSERT_NEXT(a_drain, out_valid && !out_stall && !v[NS-1] && (unused_fill == '0), !out_valid, "result repeated")

endmodule
